// ===== rtl/mlif_pkg.sv =====
// ----------------------------------------------------------------------------
// mlif_pkg: shared types and constants for the multi-branch LIF neuron
// Fixed-point widths, lane control bundle and saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package mlif_pkg;

    localparam int BRANCHES = 4;

    localparam int CUR_W   = 24;   // branch current, fA
    localparam int V_W     = 32;   // membrane voltage, nV
    localparam int J_W     = 25;   // doubled stage current, half-fA
    localparam int PD_W    = 58;   // gain * J
    localparam int PL_W    = 57;   // leak * u
    localparam int K_W     = 42;   // stage increment
    localparam int ACC_W   = 44;   // k1 + 2k2 + 2k3 + k4
    localparam int Y_W     = 48;   // voltage sum before saturation
    localparam int DV_W    = 46;   // biased dividend / quotient
    localparam int DIV_STEPS = 3;  // partial product, reciprocal product, sum

    // bias is a multiple of 6 so the floor survives the offset
    localparam logic [DV_W-1:0] DIV_BIAS = 46'h3000_0000_0000;  // 6 * 2^43
    localparam logic [DV_W-1:0] Q_OFFSET = 46'h0800_0000_0000;  // 2^43

    // 2^24 = 6 * DIV_C1 + 4; DIV_C2 = (2^25 + 1) / 3
    localparam logic [21:0] DIV_C1 = 22'd2796202;
    localparam logic [23:0] DIV_C2 = 24'd11184811;

    localparam logic [1:0] REG_LEAK  = 2'd0;
    localparam logic [1:0] REG_GAIN  = 2'd1;
    localparam logic [1:0] REG_THR   = 2'd2;

    localparam logic [1:0] STAGE_LAST = 2'd3;

    typedef struct packed {
        logic       prime;   // start item: load previous sample, clear voltage
        logic       start;   // sample item: latch currents, open RK4 step
        logic       mul;     // multiply cycle of a stage
        logic       add;     // accumulate cycle of a stage
        logic [1:0] stage;   // RK4 stage index
        logic       div;     // divide-by-6 steps
        logic       fin;     // form new voltage and threshold flag
        logic       commit;  // write back state
        logic       fire;    // merged spike flag
    } t_lane_ctl;

    function automatic logic signed [V_W-1:0] sat32(input logic signed [Y_W-1:0] x);
        logic signed [Y_W-1:0] hi;
        logic signed [Y_W-1:0] lo;
        hi = 48'sh0000_7FFF_FFFF;
        lo = -48'sh0000_8000_0000;
        if (x > hi) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (x < lo) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = x[V_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mlif_lane.sv =====
// ----------------------------------------------------------------------------
// mlif_lane: one branch of the neuron
// Holds voltage and previous current, runs the four RK4 stages through one
// multiply/accumulate pair and a reciprocal divide by six.
// ----------------------------------------------------------------------------
`default_nettype none

module mlif_lane (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire mlif_pkg::t_lane_ctl               i_ctl,
    input  wire logic signed [mlif_pkg::CUR_W-1:0] i_cur,
    input  wire logic [23:0]                       i_leak,
    input  wire logic [31:0]                       i_gain,
    input  wire logic [30:0]                       i_thr,
    output logic                                   o_fire
);

    logic signed [mlif_pkg::V_W-1:0]   r_v;
    logic signed [mlif_pkg::CUR_W-1:0] r_prev;
    logic signed [mlif_pkg::CUR_W-1:0] r_cur;
    logic signed [mlif_pkg::V_W-1:0]   r_u;
    logic signed [mlif_pkg::PD_W-1:0]  r_pd;
    logic signed [mlif_pkg::PL_W-1:0]  r_pl;
    logic signed [mlif_pkg::ACC_W-1:0] r_acc;
    logic [mlif_pkg::DV_W-1:0]         r_y;
    logic [43:0]                       r_p1;
    logic [24:0]                       r_z;
    logic [47:0]                       r_p2;
    logic [mlif_pkg::DV_W-1:0]         r_q;
    logic signed [mlif_pkg::V_W-1:0]   r_vnew;
    logic                              r_fire;

    logic signed [mlif_pkg::J_W-1:0]   w_j;
    logic signed [32:0]                w_gain;
    logic signed [24:0]                w_leak_c;
    logic signed [40:0]                w_drive;
    logic signed [32:0]                w_leakv;
    logic signed [mlif_pkg::K_W-1:0]   w_k;
    logic signed [mlif_pkg::K_W-1:0]   w_du;
    logic signed [mlif_pkg::K_W-1:0]   w_usum;
    logic signed [mlif_pkg::ACC_W-1:0] w_kw;
    logic signed [mlif_pkg::ACC_W-1:0] n_acc;
    logic [21:0]                       w_da;
    logic [23:0]                       w_db;
    logic signed [mlif_pkg::Y_W-1:0]   w_q;
    logic signed [mlif_pkg::Y_W-1:0]   w_vsum;
    logic signed [mlif_pkg::V_W-1:0]   w_vnew;

    // doubled stage current: 2*prev, prev+cur, prev+cur, 2*cur
    always_comb begin
        case (i_ctl.stage)
            2'd0:    w_j = mlif_pkg::J_W'(r_prev) <<< 1;
            2'd3:    w_j = mlif_pkg::J_W'(r_cur) <<< 1;
            default: w_j = mlif_pkg::J_W'(r_prev) + mlif_pkg::J_W'(r_cur);
        endcase
    end

    assign w_gain   = $signed({1'b0, i_gain});
    assign w_leak_c = $signed({1'b0, i_leak});

    // arithmetic shifts give the floor
    assign w_drive = r_pd[mlif_pkg::PD_W-1:17];
    assign w_leakv = r_pl[mlif_pkg::PL_W-1:24];
    assign w_k     = mlif_pkg::K_W'(w_drive) - mlif_pkg::K_W'(w_leakv);

    assign w_du   = (i_ctl.stage == 2'd2) ? w_k : (w_k >>> 1);
    assign w_usum = mlif_pkg::K_W'(r_v) + w_du;

    assign w_kw  = (i_ctl.stage == 2'd1 || i_ctl.stage == 2'd2) ?
                   (mlif_pkg::ACC_W'(w_k) <<< 1) : mlif_pkg::ACC_W'(w_k);
    assign n_acc = r_acc + w_kw;

    // y = a*2^24 + b gives y/6 = a*C1 + (4a + b)/6; the short part is
    // halved and multiplied by the reciprocal of three
    assign w_da = r_y[mlif_pkg::DV_W-1:24];
    assign w_db = r_y[23:0];

    assign w_q    = mlif_pkg::Y_W'($signed(r_q - mlif_pkg::Q_OFFSET));
    assign w_vsum = mlif_pkg::Y_W'(r_v) + w_q;
    assign w_vnew = mlif_pkg::sat32(w_vsum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= '0;
            r_prev <= '0;
        end else if (i_ctl.prime) begin
            r_v    <= '0;
            r_prev <= i_cur;
        end else if (i_ctl.commit) begin
            r_v    <= i_ctl.fire ? '0 : r_vnew;
            r_prev <= r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_cur <= i_cur;
            r_u   <= r_v;
            r_acc <= '0;
        end
        if (i_ctl.mul) begin
            r_pd <= w_gain * w_j;
            r_pl <= w_leak_c * r_u;
        end
        if (i_ctl.add) begin
            r_acc <= n_acc;
            r_u   <= mlif_pkg::sat32(mlif_pkg::Y_W'(w_usum));
            if (i_ctl.stage == mlif_pkg::STAGE_LAST) begin
                r_y <= mlif_pkg::DV_W'(n_acc) + mlif_pkg::DIV_BIAS;
            end
        end
        // r_y holds still, so each term settles in the cycle after its source
        if (i_ctl.div) begin
            r_p1 <= w_da * mlif_pkg::DIV_C1;
            r_z  <= {1'b0, w_da, 2'b00} + {1'b0, w_db};
            r_p2 <= r_z[24:1] * mlif_pkg::DIV_C2;
            r_q  <= mlif_pkg::DV_W'(r_p1) + mlif_pkg::DV_W'(r_p2[47:25]);
        end
        if (i_ctl.fin) begin
            r_vnew <= w_vnew;
            r_fire <= w_vnew > $signed({1'b0, i_thr});
        end
    end

    assign o_fire = r_fire;

endmodule

`default_nettype wire

// ===== rtl/mlif_seq.sv =====
// ----------------------------------------------------------------------------
// mlif_seq: step sequencer, spike merge and result register
// Walks the lanes through the RK4 stages and the divide, ORs the lane flags
// and holds the spike result until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mlif_seq (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire                                 i_start_req,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic                                o_spike,
    input  wire logic [mlif_pkg::BRANCHES-1:0]  i_fire,
    output mlif_pkg::t_lane_ctl                 o_ctl
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_ADD    = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_FIN    = 3'd4;
    localparam logic [2:0] ST_COMMIT = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [1:0] r_stage;
    logic [2:0] r_dcnt;
    logic       r_primed;
    logic       r_out_valid;
    logic       r_spike;

    logic w_accept;
    logic w_prime;
    logic w_slot;
    logic w_fire_any;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_prime    = w_accept && (i_start_req || !r_primed);
    assign w_slot     = !r_out_valid || i_out_ready;
    assign w_fire_any = |i_fire;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_accept && !w_prime) n_state = ST_MUL;
            ST_MUL:    n_state = ST_ADD;
            ST_ADD:    n_state = (r_stage == mlif_pkg::STAGE_LAST) ? ST_DIV : ST_MUL;
            ST_DIV:    if (r_dcnt == 3'(mlif_pkg::DIV_STEPS - 1)) n_state = ST_FIN;
            ST_FIN:    n_state = ST_COMMIT;
            ST_COMMIT: if (w_slot) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_stage     <= '0;
            r_dcnt      <= '0;
            r_primed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_prime) begin
                r_primed <= 1'b1;
            end
            if (w_accept) begin
                r_stage <= '0;
            end else if (r_state == ST_ADD) begin
                r_stage <= r_stage + 2'd1;
            end
            if (r_state == ST_DIV) begin
                r_dcnt <= r_dcnt + 3'd1;
            end else begin
                r_dcnt <= '0;
            end
            if (r_state == ST_COMMIT && w_slot) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_COMMIT && w_slot) begin
            r_spike <= w_fire_any;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_spike     = r_spike;

    always_comb begin
        o_ctl        = '0;
        o_ctl.prime  = w_prime;
        o_ctl.start  = w_accept && !w_prime;
        o_ctl.mul    = (r_state == ST_MUL);
        o_ctl.add    = (r_state == ST_ADD);
        o_ctl.stage  = r_stage;
        o_ctl.div    = (r_state == ST_DIV);
        o_ctl.fin    = (r_state == ST_FIN);
        o_ctl.commit = (r_state == ST_COMMIT) && w_slot;
        o_ctl.fire   = w_fire_any;
    end

    a_sample_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_prime) |=> (r_state == ST_MUL && r_stage == 2'd0))
        else $error("sample transfer did not start the RK4 stages");

    a_div_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_DIV) |-> $past(r_stage == mlif_pkg::STAGE_LAST))
        else $error("divide entered before the last stage");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(r_out_valid) && r_out_valid) |-> $past(r_state == ST_COMMIT))
        else $error("result raised outside commit");

    a_prime_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_prime && r_state == ST_IDLE) |=> (r_state == ST_IDLE))
        else $error("start transfer left idle");

endmodule

`default_nettype wire

// ===== rtl/multibranch_lif_neuron_rk4_top.sv =====
// ----------------------------------------------------------------------------
// multibranch_lif_neuron_rk4_top: four-branch LIF neuron with RK4 stepping
// One lane per branch integrates the membrane voltage; a sequencer merges
// the threshold flags into one spike per sample. APB register port.
//
//   Channel  Dir  Handshake                 Payload
//   in       in   i_in_valid / o_in_ready    i_start_req, i_current_0..3
//   out      out  o_out_valid / i_out_ready  o_spike
//   cfg      in   psel/penable/pwrite/pready paddr, pwdata, prdata
//
// A sample transfer runs 4 RK4 stages, each a multiply and then an accumulate
// step, then the divide-by-6 steps, a final and a commit step; the next
// transfer is taken only after the commit, so samples do not overlap.
// Start items are taken without leaving idle and give no result.
// Reset is synchronous; the block comes up ready, and its first item primes.
// A held result stalls only the commit cycle; the input side accepts
// while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module multibranch_lif_neuron_rk4_top (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire               i_start_req,
    input  wire logic [23:0]  i_current_0,
    input  wire logic [23:0]  i_current_1,
    input  wire logic [23:0]  i_current_2,
    input  wire logic [23:0]  i_current_3,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output logic              o_spike,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [23:0] r_leak;
    logic [31:0] r_gain;
    logic [30:0] r_thr;
    logic [1:0]  w_idx;

    logic signed [mlif_pkg::CUR_W-1:0] w_cur [4];
    logic [mlif_pkg::BRANCHES-1:0]     w_fire;
    mlif_pkg::t_lane_ctl               w_ctl;

    assign pready = 1'b1;
    assign w_idx  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leak <= 24'd335544;
            r_gain <= 32'd655360;
            r_thr  <= 31'd29000000;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                mlif_pkg::REG_LEAK: r_leak <= pwdata[23:0];
                mlif_pkg::REG_GAIN: r_gain <= pwdata;
                mlif_pkg::REG_THR:  r_thr  <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            mlif_pkg::REG_LEAK: prdata = {8'd0, r_leak};
            mlif_pkg::REG_GAIN: prdata = r_gain;
            mlif_pkg::REG_THR:  prdata = {1'b0, r_thr};
            default:            prdata = '0;
        endcase
    end

    assign w_cur[0] = $signed(i_current_0);
    assign w_cur[1] = $signed(i_current_1);
    assign w_cur[2] = $signed(i_current_2);
    assign w_cur[3] = $signed(i_current_3);

    mlif_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_start_req (i_start_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_spike     (o_spike),
        .i_fire      (w_fire),
        .o_ctl       (w_ctl)
    );

    for (genvar b = 0; b < mlif_pkg::BRANCHES; b++) begin : g_lane
        mlif_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_cur   (w_cur[b]),
            .i_leak  (r_leak),
            .i_gain  (r_gain),
            .i_thr   (r_thr),
            .o_fire  (w_fire[b])
        );
    end

endmodule

`default_nettype wire
